// ===== rtl/olsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olsr_pkg
// Types and constants shared by the ordered list search/remove block.
// ----------------------------------------------------------------------------
package olsr_pkg;

    localparam int VALUE_W       = 32;
    localparam int POS_W         = 6;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } state_t;

    typedef struct packed {
        action_t                    action;
        logic signed [VALUE_W-1:0]  value;
    } in_word_t;

    typedef struct packed {
        status_t                    status;
        logic [POS_W-1:0]           position;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
    } out_word_t;

    // search token passed cell to cell
    typedef struct packed {
        logic active;
        logic found;
        logic remove;
    } token_t;

    // broadcast from control to every cell
    typedef struct packed {
        logic                       wr_en;
        logic signed [VALUE_W-1:0]  data;
    } bcast_t;

endpackage : olsr_pkg
`default_nettype wire

// ===== rtl/ordered_list_search_remove.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_search_remove
// Bounded insertion-ordered list of signed 32-bit values with append, find,
// remove-first-match and clear, built as a row of DEPTH slot cells.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Append, clear,
// and find or remove on an empty list give their result word in the cycle after
// acceptance, with busy staying low. Find and remove send a search token down
// the row of DEPTH cells, one cell a cycle, and always walk the whole row:
// their result comes once the token has left the last cell, busy being high
// while the token walks. A removal closes the gap as the token passes. The
// result word is on result for the single cycle in which done is high and must
// be taken then.
module ordered_list_search_remove
    import olsr_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire in_word_t  cmd,
    output logic           busy,
    output logic           done,
    output out_word_t      result
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcast_t                    bcast;
    token_t                    head_tok;
    logic [CNT_W-1:0]          count;
    token_t                    tok   [DEPTH];
    logic [IDX_W-1:0]          pos   [DEPTH];
    logic signed [VALUE_W-1:0] entry [DEPTH];
    logic                      shift [DEPTH];

    olsr_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .tail_tok (tok[DEPTH-1]),
        .tail_pos (pos[DEPTH-1]),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .bcast    (bcast),
        .head_tok (head_tok),
        .count    (count)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        token_t                    tin;
        logic [IDX_W-1:0]          pin;
        logic signed [VALUE_W-1:0] nentry;
        logic                      nshift;

        if (i == 0)
        begin : g_head
            assign tin = head_tok;
            assign pin = '0;
        end
        else
        begin : g_body
            assign tin = tok[i-1];
            assign pin = pos[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nentry = '0;
            assign nshift = 1'b0;
        end
        else
        begin : g_link
            assign nentry = entry[i+1];
            assign nshift = shift[i+1];
        end

        olsr_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .count      (count),
            .bcast      (bcast),
            .tok_in     (tin),
            .pos_in     (pin),
            .next_entry (nentry),
            .next_shift (nshift),
            .tok_out    (tok[i]),
            .pos_out    (pos[i]),
            .entry_out  (entry[i]),
            .shift_out  (shift[i])
        );
    end

endmodule : ordered_list_search_remove
`default_nettype wire

// ===== rtl/olsr_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olsr_cell
// One list slot: holds an entry, compares it against the passing search
// token and hands its entry to the slot before it when a removal closes a gap.
// ----------------------------------------------------------------------------
module olsr_cell
    import olsr_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [CNT_W-1:0]           count,
    input  wire bcast_t                     bcast,
    input  wire token_t                     tok_in,
    input  wire logic [IDX_W-1:0]           pos_in,
    input  wire logic signed [VALUE_W-1:0]  next_entry,
    input  wire logic                       next_shift,
    output token_t                          tok_out,
    output logic [IDX_W-1:0]                pos_out,
    output logic signed [VALUE_W-1:0]       entry_out,
    output logic                            shift_out
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    token_t                    tok_reg;
    token_t                    tok_next;
    logic [IDX_W-1:0]          pos_reg;
    logic [IDX_W-1:0]          pos_next;
    logic                      in_list;
    logic                      hit;

    assign in_list   = CNT_W'(IDX) < count;
    assign hit       = tok_in.active && in_list && !tok_in.found && (entry_reg == bcast.data);
    assign shift_out = tok_in.active && tok_in.found && tok_in.remove && in_list;

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found | hit;
        pos_next       = hit ? IDX_W'(IDX) : pos_in;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (bcast.wr_en && (count == CNT_W'(IDX)))
        begin
            entry_next = bcast.data;
        end
        else if (next_shift)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        pos_reg   <= pos_next;
    end

    assign tok_out   = tok_reg;
    assign pos_out   = pos_reg;
    assign entry_out = entry_reg;

endmodule : olsr_cell
`default_nettype wire

// ===== rtl/olsr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olsr_ctrl
// Command decode, fill count, search launch and result word.
// ----------------------------------------------------------------------------
module olsr_ctrl
    import olsr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire in_word_t          cmd,
    input  wire token_t            tail_tok,
    input  wire logic [IDX_W-1:0]  tail_pos,
    output logic                   busy,
    output logic                   done,
    output out_word_t              result,
    output bcast_t                 bcast,
    output token_t                 head_tok,
    output logic [CNT_W-1:0]       count
);

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    logic                      done_next;
    out_word_t                 result_reg;
    out_word_t                 result_next;
    logic signed [VALUE_W-1:0] key_reg;
    logic                      accept;
    logic                      is_search;
    logic                      empty;
    logic                      full;

    assign accept    = start && (state_reg == S_IDLE);
    assign is_search = (cmd.action == ACT_FIND) || (cmd.action == ACT_REMOVE);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_search && !empty)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tail_tok.active)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // busy and outputs to the cell row
    always_comb
    begin
        busy            = (state_reg == S_WALK);
        head_tok.active = accept && is_search && !empty;
        head_tok.found  = 1'b0;
        head_tok.remove = (cmd.action == ACT_REMOVE);
        bcast.wr_en     = accept && (cmd.action == ACT_APPEND) && !full;
        bcast.data      = (state_reg == S_WALK) ? key_reg : cmd.value;
    end

    // result word and fill count
    always_comb
    begin
        count_next           = count_reg;
        done_next            = 1'b0;
        result_next          = result_reg;
        result_next.position = '0;
        result_next.status   = STS_OK;
        if (accept)
        begin
            case (cmd.action)
                ACT_APPEND:
                begin
                    done_next = 1'b1;
                    if (full)
                    begin
                        result_next.status = STS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_FIND, ACT_REMOVE:
                begin
                    if (empty)
                    begin
                        done_next          = 1'b1;
                        result_next.status = STS_EMPTY;
                    end
                end
                ACT_CLEAR:
                begin
                    done_next  = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
        else if ((state_reg == S_WALK) && tail_tok.active)
        begin
            done_next = 1'b1;
            if (tail_tok.found)
            begin
                result_next.position = POS_W'(tail_pos);
                if (tail_tok.remove)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            else
            begin
                result_next.status = STS_NOTFOUND;
            end
        end
        result_next.entry_count = ENTRY_COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            key_reg <= cmd.value;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign count  = count_reg;

endmodule : olsr_ctrl
`default_nettype wire

// ===== sim/ordered_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_checker
// Watches the command and result channels of the ordered list block. It keeps
// its own copy of the list, works out the result word for every command word
// taken, and compares each result word with the oldest one still due.
// ----------------------------------------------------------------------------
module ordered_list_checker
    import olsr_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire in_word_t   cmd,
    input  wire logic       done,
    input  wire out_word_t  result,
    output int              fails,
    output int              pending,
    output int              checked
);

    logic signed [VALUE_W-1:0] list_vals[$];
    out_word_t                 results_due[$];
    int                        fail_tally  = 0;
    int                        check_tally = 0;

    function automatic out_word_t list_apply(in_word_t w);
        out_word_t r;
        int        hit;
        r.status   = STS_OK;
        r.position = '0;
        hit        = -1;
        case (w.action)
            ACT_APPEND:
            begin
                if (list_vals.size() >= DEPTH)
                    r.status = STS_FULL;
                else
                    list_vals.push_back(w.value);
            end
            ACT_FIND, ACT_REMOVE:
            begin
                if (list_vals.size() == 0)
                    r.status = STS_EMPTY;
                else
                begin
                    for (int i = 0; i < list_vals.size() && hit < 0; i++)
                        if (list_vals[i] == w.value)
                            hit = i;
                    if (hit < 0)
                        r.status = STS_NOTFOUND;
                    else
                    begin
                        r.position = POS_W'(hit);
                        if (w.action == ACT_REMOVE)
                            list_vals.delete(hit);
                    end
                end
            end
            ACT_CLEAR:
                list_vals.delete();
            default:
                r.status = STS_OK;
        endcase
        r.entry_count = ENTRY_COUNT_W'(list_vals.size());
        return r;
    endfunction

    task automatic flag_field(input string field, input int want, input int got);
        fail_tally++;
        if (fail_tally <= 40)
            $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            list_vals.delete();
            results_due.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= 40)
                        $error("unexpected result word: status %0d position %0d entry_count %0d",
                               result.status, result.position, result.entry_count);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_tally++;
                    if (result.status !== want.status)
                        flag_field("status", want.status, result.status);
                    if (result.position !== want.position)
                        flag_field("position", want.position, result.position);
                    if (result.entry_count !== want.entry_count)
                        flag_field("entry_count", want.entry_count, result.entry_count);
                end
            end
            if (start && !busy)
                results_due.push_back(list_apply(cmd));
            pending <= results_due.size();
            fails   <= fail_tally;
            checked <= check_tally;
        end
    end

endmodule : ordered_list_checker

// ===== sim/ordered_list_search_remove_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_search_remove_test
// Drives append, find, remove and clear words into the ordered list block in
// random bursts: a short directed run over the empty, head, tail, duplicate
// and not-found cases, then segments that fill, drain or mix the list, with
// full-list appends along the way. The checker beside the block does the
// predicting and comparing; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module ordered_list_search_remove_test;
    import olsr_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEMS       = 750;
    localparam int STALL_LIMIT = 8 * (DEPTH + 1) + 200;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_MIXED } mix_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  cmd   = '0;
    logic      busy;
    logic      done;
    out_word_t result;
    int        fails;
    int        pending;
    int        checked;

    int        burst_left   = 0;
    int        stall_cycles = 0;
    int        sent[4]      = '{default: 0};

    // values already appended, so finds and removes hit often
    logic signed [VALUE_W-1:0] recent_vals[DEPTH];
    int                        recent_fill = 0;
    int                        recent_wr   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ordered_list_search_remove #(
        .DEPTH  (DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    ordered_list_checker #(
        .DEPTH   (DEPTH)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .fails   (fails),
        .pending (pending),
        .checked (checked)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic signed [VALUE_W-1:0] pick_value(input int hit_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < hit_pct && recent_fill > 0)
            return recent_vals[$urandom_range(0, recent_fill - 1)];
        if (r < hit_pct + 15)
            return $urandom_range(0, 6) - 3;
        if (r < hit_pct + 22)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input action_t act, input logic signed [VALUE_W-1:0] val);
        in_word_t w;
        int       gap;
        w.action = act;
        w.value  = val;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        sent[int'(act)]++;
        if (act == ACT_APPEND)
        begin
            recent_vals[recent_wr] = val;
            recent_wr = (recent_wr + 1) % DEPTH;
            if (recent_fill < DEPTH)
                recent_fill++;
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        mix_t mix;
        int   seg_len;
        int   items;
        int   r;
        int   app_pct;
        int   find_pct;
        int   clr_pct;
        bit   paused;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, duplicates, head, tail and misses
        send_word(ACT_FIND,   32'sd5);
        send_word(ACT_REMOVE, 32'sd0);
        send_word(ACT_APPEND, 32'h8000_0000);
        send_word(ACT_APPEND, 32'h7FFF_FFFF);
        send_word(ACT_APPEND, 32'sd0);
        send_word(ACT_APPEND, -32'sd1);
        send_word(ACT_APPEND, 32'sd5);
        send_word(ACT_APPEND, 32'sd5);
        send_word(ACT_FIND,   32'sd5);
        send_word(ACT_FIND,   32'h7FFF_FFFF);
        send_word(ACT_FIND,   32'sd123);
        send_word(ACT_FIND,   32'h8000_0000);
        send_word(ACT_REMOVE, 32'sd5);
        send_word(ACT_REMOVE, 32'sd5);
        send_word(ACT_REMOVE, 32'sd5);
        send_word(ACT_REMOVE, 32'h8000_0000);
        send_word(ACT_REMOVE, -32'sd1);
        send_word(ACT_FIND,   32'sd0);
        send_word(ACT_CLEAR,  32'hFFFF_FFFF);
        send_word(ACT_CLEAR,  32'h0000_0000);
        send_word(ACT_FIND,   32'sd0);
        send_word(ACT_REMOVE, 32'h7FFF_FFFF);

        items  = 0;
        mix    = MIX_FILL;
        paused = 1'b0;
        while (items < ITEMS)
        begin
            case (mix)
                MIX_FILL:
                begin
                    seg_len  = 80;
                    app_pct  = 85;
                    find_pct = 8;
                    clr_pct  = 0;
                end
                MIX_DRAIN:
                begin
                    seg_len  = $urandom_range(20, 60);
                    app_pct  = 10;
                    find_pct = 30;
                    clr_pct  = 2;
                end
                default:
                begin
                    seg_len  = $urandom_range(20, 60);
                    app_pct  = 40;
                    find_pct = 30;
                    clr_pct  = 3;
                end
            endcase
            if (seg_len > ITEMS - items)
                seg_len = ITEMS - items;
            repeat (seg_len)
            begin
                r = $urandom_range(0, 99);
                if (r < app_pct)
                    send_word(ACT_APPEND, pick_value(10));
                else if (r < app_pct + find_pct)
                    send_word(ACT_FIND, pick_value(60));
                else if (r < 100 - clr_pct)
                    send_word(ACT_REMOVE, pick_value(60));
                else
                    send_word(ACT_CLEAR, pick_value(0));
                items++;
            end
            if (!paused || $urandom_range(0, 2) == 0)
            begin
                drain_results();
                paused = 1'b1;
            end
            mix = mix_t'($urandom_range(0, 2));
        end

        drain_results();
        repeat (DEPTH + 8) @(posedge clk);
        @(negedge clk);
        $display("covered %0d words: %0d append, %0d find, %0d remove, %0d clear",
                 sent[0] + sent[1] + sent[2] + sent[3], sent[int'(ACT_APPEND)],
                 sent[int'(ACT_FIND)], sent[int'(ACT_REMOVE)], sent[int'(ACT_CLEAR)]);
        $display("%0d result words checked, %0d mismatches", checked, fails);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule : ordered_list_search_remove_test
